// ===== hw/rtl/mfq_pkg.sv =====
// Package for the multilevel feedback queue scheduler.
// Holds default sizes, field widths, job record, status and state codes.
// No dependencies.
package mfq_pkg;

  localparam int LEVELS_DEF      = 5;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int BASE_W = 10;
  localparam logic [BASE_W-1:0] BASE_SLICE_RST = 10'd10;

  localparam int ID_W   = 8;
  localparam int TIME_W = 16;
  localparam int WAIT_W = 32;
  localparam int OUT_W  = 80;

  localparam logic ACT_ARRIVE   = 1'b0;
  localparam logic ACT_DISPATCH = 1'b1;

  localparam logic REG_BASE_SLICE = 1'b0;

  typedef struct packed {
    logic [TIME_W-1:0] used;
    logic [TIME_W-1:0] need;
    logic [ID_W-1:0]   id;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  typedef enum logic [1:0] {
    STAT_ACCEPT,
    STAT_RUN,
    STAT_EMPTY,
    STAT_FULL
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HOLD,
    ST_READ,
    ST_MUL
  } st_t;

endpackage

// ===== hw/rtl/mfq_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
// Depends on mfq_pkg for default sizes.
module mfq_ram import mfq_pkg::*; #(
  parameter int WIDTH = JOB_W,
  parameter int DEPTH = LEVELS_DEF * QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/multilevel_feedback_queue_scheduler.sv =====
// Multilevel feedback queue scheduler, top level.
// Depends on mfq_pkg and mfq_ram (job records, one entry per queue slot).
//
// Input channel s_*: one beat is one event. s_tuser selects arrival or
// dispatch; an arrival carries job id and needed time in s_tdata.
// Output channel m_*: exactly one result beat per input beat, in order.
// m_tuser is the status, m_tdata the dispatch details and the wait total.
// Config: APB port, one register (base_slice) at byte address 0.
//
// Timing: arrivals and empty dispatches answer from the idle state, or from
// the hold state while the output register is busy. A real dispatch runs as
// queue memory read, then the used-time update and the slice times
// queued-jobs product, then the wait total update with the write-back of
// the demoted job. One event is in flight at a time, so s_tready is high
// only in the idle state. The result sits in an output register; a new
// beat is taken while it waits. If the receiver stalls, the block holds the
// next result in its working state until the output register frees up.
// Reset clears all queues, the wait total and base_slice (back to 10); the
// queue memory itself is not cleared and needs no clearing pass.
module multilevel_feedback_queue_scheduler import mfq_pkg::*; #(
  parameter int LEVELS      = LEVELS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // job_id [7:0], needed_time [23:8]
  input  logic [23:0]       s_tdata,
  // action [0]
  input  logic              s_tuser,
  input  logic              s_tvalid,
  output logic              s_tready,
  // run_id [7:0], run_level [10:8], slice_granted [24:11], used_after [40:25],
  // finished [41], wait_total [73:42], zero [79:74]
  output logic [OUT_W-1:0]  m_tdata,
  // status [1:0]
  output logic [1:0]        m_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int LVL_W     = $clog2(LEVELS);
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int TOT_W     = $clog2(LEVELS * QUEUE_DEPTH + 1);
  localparam int SLICE_W   = BASE_W + LEVELS - 1;
  localparam int SUM_W     = ((SLICE_W > TIME_W) ? SLICE_W : TIME_W) + 1;
  localparam int PROD_W    = SLICE_W + TOT_W;
  localparam int ADDR_W    = LVL_W + PTR_W;
  localparam int MEM_DEPTH = LEVELS * (2 ** PTR_W);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // registers
  logic [BASE_W-1:0] base_slice;
  logic [PTR_W-1:0]  head_ptr [LEVELS];
  logic [PTR_W-1:0]  tail_ptr [LEVELS];
  logic [CNT_W-1:0]  level_count [LEVELS];
  logic [TOT_W-1:0]  job_total;
  logic [WAIT_W-1:0] wait_accum;
  st_t               state, state_next;

  logic              hold_action;
  logic [ID_W-1:0]   hold_id;
  logic [TIME_W-1:0] hold_need;

  logic [LVL_W-1:0]   run_lvl;
  logic [SLICE_W-1:0] run_slice;
  logic [TOT_W-1:0]   run_others;
  logic [ID_W-1:0]    run_id;
  logic [TIME_W-1:0]  run_need;
  logic [TIME_W-1:0]  run_used;
  logic               run_done;
  logic [PROD_W-1:0]  run_prod;

  // combinational
  logic              s_fire, out_free;
  logic              any_ready;
  logic [LVL_W-1:0]  top_lvl;
  logic              cur_action;
  logic [ID_W-1:0]   cur_id;
  logic [TIME_W-1:0] cur_need;
  logic              level0_full;
  logic              start_pop, do_short, do_finish, arrive_push, demote_push;
  logic [LVL_W-1:0]  nxt_lvl, dst_lvl, push_lvl;
  logic [SUM_W-1:0]  used_sum;
  logic [TIME_W-1:0] used_sat;
  logic [WAIT_W:0]   wait_sum;
  logic [WAIT_W-1:0] wait_next;
  job_t              rd_job, wr_job;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [JOB_W-1:0]  mem_rdata;
  logic              cfg_we;

  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    any_ready = 1'b0;
    top_lvl   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (level_count[i] != '0) begin
        any_ready = 1'b1;
        top_lvl   = LVL_W'(i);
      end
    end
  end

  assign cur_action  = (state == ST_HOLD) ? hold_action : s_tuser;
  assign cur_id      = (state == ST_HOLD) ? hold_id : s_tdata[7:0];
  assign cur_need    = (state == ST_HOLD) ? hold_need : s_tdata[23:8];
  assign level0_full = level_count[0] == CNT_W'(QUEUE_DEPTH);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_tuser == ACT_DISPATCH && any_ready) begin
            state_next = ST_READ;
          end else if (!out_free) begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: state_next = ST_MUL;
      ST_MUL: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    s_tready  = 1'b0;
    start_pop = 1'b0;
    do_short  = 1'b0;
    do_finish = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        start_pop = s_fire && s_tuser == ACT_DISPATCH && any_ready;
        do_short  = s_fire && !(s_tuser == ACT_DISPATCH && any_ready) && out_free;
      end
      ST_HOLD: do_short  = out_free;
      ST_MUL:  do_finish = out_free;
      default: ;
    endcase
  end

  assign arrive_push = do_short && cur_action == ACT_ARRIVE && !level0_full;
  assign demote_push = do_finish && !run_done;

  // demotion target, falls back to the own level when the lower one is full
  assign nxt_lvl  = (run_lvl == LVL_W'(LEVELS - 1)) ? run_lvl : LVL_W'(run_lvl + 1'b1);
  assign dst_lvl  = (level_count[nxt_lvl] == CNT_W'(QUEUE_DEPTH)) ? run_lvl : nxt_lvl;
  assign push_lvl = arrive_push ? '0 : dst_lvl;

  // job memory
  assign rd_job = job_t'(mem_rdata);

  always_comb begin
    if (arrive_push) begin
      wr_job.used = '0;
      wr_job.need = cur_need;
      wr_job.id   = cur_id;
    end else begin
      wr_job.used = run_used;
      wr_job.need = run_need;
      wr_job.id   = run_id;
    end
  end

  assign mem_we    = arrive_push || demote_push;
  assign mem_waddr = {push_lvl, tail_ptr[push_lvl]};
  assign mem_raddr = {top_lvl, head_ptr[top_lvl]};

  mfq_ram #(
    .WIDTH (JOB_W),
    .DEPTH (MEM_DEPTH)
  ) u_job_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wr_job),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // arithmetic
  assign used_sum  = SUM_W'(rd_job.used) + SUM_W'(run_slice);
  assign used_sat  = (used_sum > SUM_W'({TIME_W{1'b1}})) ? {TIME_W{1'b1}} : used_sum[TIME_W-1:0];
  assign wait_sum  = {1'b0, wait_accum} + (WAIT_W + 1)'(run_prod);
  assign wait_next = wait_sum[WAIT_W] ? {WAIT_W{1'b1}} : wait_sum[WAIT_W-1:0];

  // state register and queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      job_total  <= '0;
      wait_accum <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        head_ptr[i]    <= '0;
        tail_ptr[i]    <= '0;
        level_count[i] <= '0;
      end
    end else begin
      state <= state_next;
      for (int i = 0; i < LEVELS; i++) begin
        if (start_pop && top_lvl == LVL_W'(i)) begin
          head_ptr[i]    <= ptr_inc(head_ptr[i]);
          level_count[i] <= level_count[i] - 1'b1;
        end
        if (mem_we && push_lvl == LVL_W'(i)) begin
          tail_ptr[i]    <= ptr_inc(tail_ptr[i]);
          level_count[i] <= level_count[i] + 1'b1;
        end
      end
      if (arrive_push) begin
        job_total <= job_total + 1'b1;
      end else if (do_finish && run_done) begin
        job_total <= job_total - 1'b1;
      end
      if (do_finish) begin
        wait_accum <= wait_next;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (s_fire) begin
      hold_action <= s_tuser;
      hold_id     <= s_tdata[7:0];
      hold_need   <= s_tdata[23:8];
    end
    if (start_pop) begin
      run_lvl    <= top_lvl;
      run_slice  <= SLICE_W'(base_slice) << top_lvl;
      run_others <= job_total - 1'b1;
    end
    if (state == ST_READ) begin
      run_id   <= rd_job.id;
      run_need <= rd_job.need;
      run_used <= used_sat;
      run_done <= used_sat >= rd_job.need;
      run_prod <= PROD_W'(run_slice) * PROD_W'(run_others);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_short || do_finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_finish) begin
      m_tuser <= STAT_RUN;
      m_tdata <= {6'd0, wait_next, run_done, run_used, 14'(run_slice), 3'(run_lvl), run_id};
    end else if (do_short) begin
      if (cur_action == ACT_DISPATCH) begin
        m_tuser <= STAT_EMPTY;
      end else if (level0_full) begin
        m_tuser <= STAT_FULL;
      end else begin
        m_tuser <= STAT_ACCEPT;
      end
      m_tdata <= {6'd0, wait_accum, 42'd0};
    end
  end

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && paddr[2] == REG_BASE_SLICE;
  assign prdata = (paddr[2] == REG_BASE_SLICE) ? 32'(base_slice) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_slice <= BASE_SLICE_RST;
    end else if (cfg_we) begin
      base_slice <= pwdata[BASE_W-1:0];
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the multilevel feedback queue scheduler.
// Uses mfq_pkg. A built-in scheduler predictor works out each result beat, and the
// beats are checked in order. Stimulus is directed, then random bursts over several slices.
module tb_top;
  import mfq_pkg::*;

  localparam int LVLS = LEVELS_DEF;
  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] BASE_SLICE_ADDR = 3'(4 * int'(REG_BASE_SLICE));

  typedef struct packed {
    logic             act;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] need;
  } sched_item_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   run_id;
    logic [2:0]        run_level;
    logic [13:0]       slice;
    logic [TIME_W-1:0] used_after;
    logic              finished;
    logic [WAIT_W-1:0] wait_total;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [23:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  multilevel_feedback_queue_scheduler i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  job_t run_q [LVLS][$];
  logic [BASE_W-1:0] slice_base = BASE_SLICE_RST;
  logic [WAIT_W-1:0] wait_sum = '0;

  sched_item_t pending[$];
  sched_res_t due_results[$];
  sched_item_t offer;
  int mismatches = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  int quiet = 0;
  int cyc = 0;
  logic calm;

  assign calm = (cyc >= 2500) && (cyc < 4000);

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic void schedule_step(logic act, logic [ID_W-1:0] id, logic [TIME_W-1:0] need);
    sched_res_t r;
    job_t j;
    int lvl;
    int dst;
    longint unsigned slice, used, others, total;
    r = '0;
    if (act == ACT_ARRIVE) begin
      if (run_q[0].size() >= QDEPTH) begin
        r.status = STAT_FULL;
      end else begin
        j.id = id;
        j.need = need;
        j.used = '0;
        run_q[0].push_back(j);
        r.status = STAT_ACCEPT;
      end
    end else begin
      lvl = -1;
      for (int l = LVLS - 1; l >= 0; l--)
        if (run_q[l].size() != 0) lvl = l;
      if (lvl < 0) begin
        r.status = STAT_EMPTY;
      end else begin
        j = run_q[lvl].pop_front();
        slice = longint'(slice_base) << lvl;
        used = j.used + slice;
        if (used > 65535) used = 65535;
        others = 0;
        for (int l = 0; l < LVLS; l++) others += run_q[l].size();
        total = wait_sum + slice * others;
        wait_sum = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
        if (used < j.need) begin
          dst = (lvl + 1 < LVLS) ? lvl + 1 : lvl;
          if (run_q[dst].size() >= QDEPTH) dst = lvl;
          j.used = used[15:0];
          run_q[dst].push_back(j);
        end
        r.status = STAT_RUN;
        r.run_id = j.id;
        r.run_level = 3'(lvl);
        r.slice = slice[13:0];
        r.used_after = used[15:0];
        r.finished = (used >= j.need);
      end
    end
    r.wait_total = wait_sum;
    due_results.push_back(r);
  endfunction

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      note_failure($sformatf("result %0d %s: expected %0h, got %0h",
                             results_seen, name, want, got));
  endfunction

  function automatic void check_result();
    sched_res_t e;
    if (due_results.size() == 0) begin
      note_failure($sformatf("result %0d: beat with nothing expected", results_seen));
    end else begin
      e = due_results.pop_front();
      field_check("status", 32'(e.status), 32'(m_tuser));
      field_check("run_id", 32'(e.run_id), 32'(m_tdata[7:0]));
      field_check("run_level", 32'(e.run_level), 32'(m_tdata[10:8]));
      field_check("slice_granted", 32'(e.slice), 32'(m_tdata[24:11]));
      field_check("used_after", 32'(e.used_after), 32'(m_tdata[40:25]));
      field_check("finished", 32'(e.finished), 32'(m_tdata[41]));
      field_check("wait_total", e.wait_total, m_tdata[73:42]);
    end
    results_seen++;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) schedule_step(offer.act, offer.id, offer.need);
      if (!s_tvalid || s_tready) begin
        if (pending.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
          offer = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= offer.act;
          s_tdata <= {offer.need, offer.id};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!held_once && results_seen >= 400 && pending.size() > 40) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 12);
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic void put(logic act, logic [ID_W-1:0] id, logic [TIME_W-1:0] need);
    sched_item_t it;
    it.act = act;
    it.id = id;
    it.need = need;
    pending.push_back(it);
  endfunction

  function automatic logic [TIME_W-1:0] pick_need();
    case ($urandom_range(7))
      0: return '0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(64, 1));
      3: return 16'($urandom_range(4096, 64));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // mostly arrival bursts followed by dispatch bursts, the rest single random beats
  function automatic void queue_traffic(int n);
    int count;
    int k;
    count = 0;
    while (count < n) begin
      if ($urandom_range(99) < 85) begin
        k = $urandom_range(18, 1);
        repeat (k) put(ACT_ARRIVE, 8'($urandom_range(255)), pick_need());
        count += k;
        k = $urandom_range(24, 1);
        repeat (k) put(ACT_DISPATCH, 8'($urandom_range(255)), 16'($urandom_range(65535)));
        count += k;
      end else begin
        put(1'($urandom_range(1)), 8'($urandom_range(255)), pick_need());
        count++;
      end
    end
  endfunction

  task automatic base_slice_access(input logic wr, input logic [BASE_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= BASE_SLICE_ADDR;
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (wr) slice_base = val;
    else if (prdata[BASE_W-1:0] !== slice_base)
      note_failure($sformatf("base_slice read: expected %0h, got %0h", slice_base, prdata));
  endtask

  task automatic wait_idle();
    while (!(pending.size() == 0 && !s_tvalid && due_results.size() == 0)) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    logic [BASE_W-1:0] steps [8];
    steps = '{10'd1, 10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd0, 10'd10, 10'd0};
    steps[5] = 10'($urandom_range(1023, 1));
    steps[7] = 10'($urandom_range(1023, 1));
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    base_slice_access(1'b0, '0);

    // empty dispatch, zero need, exact-fit need, extreme ids, descent to the lowest level
    put(ACT_DISPATCH, 8'hFF, 16'hFFFF);
    put(ACT_ARRIVE, 8'h00, 16'h0000);
    put(ACT_ARRIVE, 8'hFF, 16'hFFFF);
    put(ACT_ARRIVE, 8'h5A, 16'd10);
    put(ACT_ARRIVE, 8'hA5, 16'd11);
    repeat (9) put(ACT_DISPATCH, 8'h00, 16'h0000);
    put(ACT_ARRIVE, 8'h3C, 16'h5555);
    put(ACT_ARRIVE, 8'hC3, 16'hAAAA);
    repeat (4) put(ACT_DISPATCH, 8'h00, 16'h0000);
    wait_idle();

    for (int i = 0; i < 8; i++) begin
      base_slice_access(1'b1, steps[i]);
      base_slice_access(1'b0, '0);
      queue_traffic(160);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (due_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", due_results.size()));
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
